// File: src/prrq_pkg.sv
`timescale 1ns / 1ps
package prrq_pkg;

  // Sizes of the queue
  localparam int unsigned ACCOUNTS   = 16;
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned ACCT_W     = 4;
  localparam int unsigned PTR_W      = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned TOTAL_W    = 9;
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned ADDR_W     = ACCT_W + PTR_W;

  // Request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic                account_valid;
    logic [ACCT_W-1:0]   account_id;
    logic [HANDLE_W-1:0] item_handle;
  } req_t;

  typedef struct packed {
    logic                item_valid;
    logic [HANDLE_W-1:0] out_handle;
    logic [ACCT_W-1:0]   out_account;
    logic [TOTAL_W-1:0]  total_items;
    logic [1:0]          status;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// File: src/prrq_ctrl.sv
`timescale 1ns / 1ps
module prrq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               out_valid_o,
  output prrq_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Take a request whenever not executing one
  assign busy        = (state_q == S_EXEC);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.load  = start && !busy;
  assign cmd_o.exec  = (state_q == S_EXEC);

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/prrq_datapath.sv
`timescale 1ns / 1ps
module prrq_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prrq_pkg::cmd_t        cmd_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_data_i,
  input  prrq_pkg::req_t        req_i,
  output prrq_pkg::res_t        res_o
);

  localparam int unsigned NA = prrq_pkg::ACCOUNTS;
  localparam int unsigned AW = prrq_pkg::ACCT_W;
  localparam int unsigned PW = prrq_pkg::PTR_W;
  localparam int unsigned CW = prrq_pkg::CNT_W;
  localparam int unsigned LW = prrq_pkg::LEN_W;
  localparam int unsigned TW = prrq_pkg::TOTAL_W;
  localparam int unsigned HW = prrq_pkg::HANDLE_W;

  prrq_pkg::req_t req_q;
  logic           rr_on_q;
  logic [PW-1:0]  head_q  [NA];
  logic [CW-1:0]  count_q [NA];
  logic [AW-1:0]  order_q [NA];
  logic [LW-1:0]  len_q;
  logic [AW-1:0]  cursor_q;
  logic [TW-1:0]  total_q;
  logic           valid_q;
  logic [AW-1:0]  acct_q;
  logic [1:0]     status_q;
  logic [HW-1:0]  mem [NA * prrq_pkg::FIFO_DEPTH];
  logic [HW-1:0]  rd_q;

  logic                      is_enq;
  logic [AW-1:0]             enq_acct;
  logic [AW-1:0]             pos;
  logic [AW-1:0]             acct;
  logic [CW-1:0]             cnt;
  logic [PW-1:0]             hd;
  logic                      full;
  logic                      empty;
  logic [PW-1:0]             slot;
  logic                      do_write;
  logic                      do_serve;
  logic                      do_drop;
  logic [LW-1:0]             nxt;
  logic [LW-1:0]             new_len;
  logic [LW-1:0]             adj;
  logic [LW-1:0]             cur_drop;

  // Decode the held request
  always_comb begin
    is_enq   = (req_q.req_type == prrq_pkg::REQ_ENQ);
    enq_acct = (rr_on_q && req_q.account_valid) ? req_q.account_id : '0;
    pos      = ({1'b0, cursor_q} >= len_q) ? '0 : cursor_q;
    acct     = is_enq ? enq_acct : order_q[pos];
    cnt      = count_q[acct];
    hd       = head_q[acct];
    full     = (cnt == CW'(prrq_pkg::FIFO_DEPTH));
    empty    = (total_q == '0) || (len_q == '0);
    slot     = hd + cnt[PW-1:0];
    do_write = cmd_i.exec && is_enq && !full;
    do_serve = cmd_i.exec && !is_enq && !empty;
    do_drop  = (cnt == CW'(1));
    // Cursor after serving, then closed up over the removed entry
    nxt      = ({1'b0, pos} + LW'(1) == len_q) ? '0 : {1'b0, pos} + LW'(1);
    new_len  = len_q - LW'(1);
    adj      = (nxt > {1'b0, pos}) ? nxt - LW'(1) : nxt;
    cur_drop = ((new_len == '0) || (adj >= new_len)) ? '0 : adj;
  end

  // Hold the request and the mode register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      rr_on_q <= cfg_data_i;
    end
  end

  // Queue bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      len_q    <= '0;
      cursor_q <= '0;
      total_q  <= '0;
    end else if (do_write) begin
      count_q[acct] <= cnt + CW'(1);
      total_q       <= total_q + TW'(1);
      if (cnt == '0 && len_q < LW'(NA)) len_q <= len_q + LW'(1);
    end else if (do_serve) begin
      head_q[acct]  <= hd + PW'(1);
      count_q[acct] <= cnt - CW'(1);
      total_q       <= total_q - TW'(1);
      if (do_drop) begin
        len_q    <= new_len;
        cursor_q <= cur_drop[AW-1:0];
      end else begin
        cursor_q <= nxt[AW-1:0];
      end
    end
  end

  // Append or drop entries of the active list
  always_ff @(posedge clk_i) begin
    if (do_write && cnt == '0 && len_q < LW'(NA)) begin
      order_q[len_q[AW-1:0]] <= acct;
    end else if (do_serve && do_drop) begin
      for (int i = 0; i < NA - 1; i++) begin
        if (AW'(i) >= pos) order_q[i] <= order_q[i + 1];
      end
    end
  end

  // Result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      acct_q   <= '0;
      status_q <= prrq_pkg::ST_OK;
    end else if (cmd_i.exec) begin
      valid_q  <= do_serve;
      acct_q   <= do_serve ? acct : '0;
      if (is_enq) status_q <= full ? prrq_pkg::ST_FULL : prrq_pkg::ST_OK;
      else        status_q <= empty ? prrq_pkg::ST_EMPTY : prrq_pkg::ST_OK;
    end
  end

  // Handle store
  always_ff @(posedge clk_i) begin
    if (do_write) mem[{acct, slot}] <= req_q.item_handle;
    if (cmd_i.exec) rd_q <= mem[{acct, hd}];
  end

  assign res_o.item_valid  = valid_q;
  assign res_o.out_handle  = valid_q ? rd_q : '0;
  assign res_o.out_account = acct_q;
  assign res_o.total_items = total_q;
  assign res_o.status      = status_q;

endmodule

// File: src/per_account_round_robin_queue.sv
`timescale 1ns / 1ps
// Per-account round-robin queue of item handles. A request is taken when start
// is high and busy is low; its result shows on res_o for exactly one cycle with
// out_valid_o high, in the response state after the execute state; the receiver
// cannot stall it. A new request may be given while the result shows. The execute
// state updates the account tables and handle memory; the response state shows
// the registered memory read. The user must write the mode register through the
// cfg channel only while no request is in flight; the block does not enforce it.
module per_account_round_robin_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  prrq_pkg::req_t req_i,
  output logic           out_valid_o,
  output prrq_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  prrq_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  prrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  prrq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .res_o      (res_o)
  );

endmodule
